@@ src/pfe_pkg.sv @@
// shared types, constants and codes for the playfair encryptor
`default_nettype none

package pfe_pkg;

    // letter codes and field widths
    localparam int LETTER_W     = 5;
    localparam int LETTERS      = 26;
    localparam int GRID_SIDE_DF = 5;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 16;
    localparam int MODE_W       = 2;

    localparam logic [LETTER_W-1:0] CODE_Q = LETTER_W'(16);
    localparam logic [LETTER_W-1:0] CODE_X = LETTER_W'(23);

    // request kinds carried on tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_KEY      = 2'd0,
        MODE_KEY_DONE = 2'd1,
        MODE_MSG      = 2'd2,
        MODE_END      = 2'd3
    } t_mode;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_LOOK_A,
        S_LOOK_B,
        S_GRID,
        S_CELL_A,
        S_CELL_B,
        S_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic ready;      // input side may take a request
        logic take;       // request accepted this cycle
        logic fill_step;  // place one alphabet letter during square fill
        logic look_sel;   // place lookup address: 0 first letter, 1 second
        logic load_pa;    // capture place of first letter
        logic load_pb;    // capture place of second letter
        logic cell_sel;   // cell lookup address: 0 first cipher, 1 second
        logic load_first; // capture first cipher letter
        logic emit;       // load output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_fill;  // pending request is key done
        logic need_pair;  // pending request completes a pair
        logic fill_last;  // fill walk at its final letter
        logic out_free;   // output register can take a result
    } t_status;

    // valid cipher letter: inside the alphabet and not Q
    function automatic logic letter_ok(input logic [LETTER_W-1:0] c);
        return (c < LETTER_W'(LETTERS)) && (c != CODE_Q);
    endfunction

endpackage

`default_nettype wire

@@ src/pfe_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/pfe_ctrl.sv @@
// controller state machine for the playfair encryptor
`default_nettype none

module pfe_ctrl
    import pfe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.need_fill) begin
                    n_state = S_FILL;
                end else if (i_in_valid && i_status.need_pair) begin
                    n_state = S_LOOK_A;
                end
            end
            S_FILL: begin
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK_A: n_state = S_LOOK_B;
            S_LOOK_B: n_state = S_GRID;
            S_GRID:   n_state = S_CELL_A;
            S_CELL_A: n_state = S_CELL_B;
            S_CELL_B: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                o_cmd.take  = i_in_valid;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            S_LOOK_A: begin
                o_cmd.look_sel = 1'b0;
            end
            S_LOOK_B: begin
                o_cmd.look_sel = 1'b1;
                o_cmd.load_pa  = 1'b1;
            end
            S_GRID: begin
                o_cmd.load_pb = 1'b1;
            end
            S_CELL_A: begin
                o_cmd.cell_sel = 1'b0;
            end
            S_CELL_B: begin
                o_cmd.cell_sel   = 1'b1;
                o_cmd.load_first = 1'b1;
            end
            S_EMIT: begin
                o_cmd.cell_sel = 1'b1;
                o_cmd.emit     = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/pfe_dp.sv @@
// datapath: square tables, pair state, cipher rules and output register
`default_nettype none

module pfe_dp
    import pfe_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [MODE_W-1:0]   i_in_mode,
    input  wire logic [LETTER_W-1:0] i_in_letter,
    input  wire logic                i_out_ready,
    output t_status                  o_status,
    output logic                     o_out_valid,
    output logic [LETTER_W-1:0]      o_cipher_first,
    output logic [LETTER_W-1:0]      o_cipher_second,
    output logic                     o_last_pair
);

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int FILL_W  = $clog2(CELLS + 1);
    localparam int RW      = $clog2(GRID_SIDE);
    localparam int PLACE_AW = $clog2(LETTERS);

    // row of a cell index by comparing against row starts
    function automatic logic [RW-1:0] row_of(input logic [CELL_AW-1:0] p);
        logic [RW-1:0] r;
        r = '0;
        for (int i = 1; i < GRID_SIDE; i++) begin
            if (p >= CELL_AW'(i * GRID_SIDE)) begin
                r = RW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [RW-1:0] col_of(input logic [CELL_AW-1:0] p,
                                             input logic [RW-1:0]      r);
        logic [CELL_AW-1:0] base;
        base = CELL_AW'(int'(r) * GRID_SIDE);
        return RW'(p - base);
    endfunction

    // step one place along a row or column with wrap
    function automatic logic [RW-1:0] next_idx(input logic [RW-1:0] x);
        return (x == RW'(GRID_SIDE - 1)) ? '0 : RW'(x + 1'b1);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_at(input logic [RW-1:0] r,
                                                  input logic [RW-1:0] c);
        return CELL_AW'(int'(r) * GRID_SIDE + int'(c));
    endfunction

    // control state
    logic [LETTERS-1:0]  r_used;
    logic [FILL_W-1:0]   r_fill;
    logic [LETTER_W-1:0] r_k;
    logic [LETTER_W-1:0] r_held;
    logic                r_held_valid;
    logic                r_out_valid;

    // payload registers
    logic [LETTER_W-1:0] r_a;
    logic [LETTER_W-1:0] r_b;
    logic                r_pair_last;
    logic [CELL_AW-1:0]  r_pa;
    logic [CELL_AW-1:0]  r_pb;
    logic [LETTER_W-1:0] r_first_hold;
    logic [LETTER_W-1:0] r_first;
    logic [LETTER_W-1:0] r_second;
    logic                r_last;

    // ram ports
    logic [CELL_AW-1:0]  place_rdata;
    logic [LETTER_W-1:0] cell_rdata;
    logic [CELL_AW-1:0]  cell_raddr;
    logic [PLACE_AW-1:0] place_raddr;

    // placement of one letter, from the input or the fill walk
    logic [LETTER_W-1:0] put_letter;
    logic                put_try;
    logic                put_we;
    t_mode               in_mode;
    logic                in_ok;

    assign in_mode    = t_mode'(i_in_mode);
    assign in_ok      = letter_ok(i_in_letter);
    assign put_letter = i_cmd.fill_step ? r_k : i_in_letter;
    assign put_try    = i_cmd.fill_step || (i_cmd.take && (in_mode == MODE_KEY));
    assign put_we     = put_try && letter_ok(put_letter)
                        && (r_fill < FILL_W'(CELLS)) && !r_used[put_letter];

    // status toward the controller
    always_comb begin
        o_status.need_fill = (in_mode == MODE_KEY_DONE);
        o_status.need_pair = r_held_valid
                             && ((in_mode == MODE_END) || ((in_mode == MODE_MSG) && in_ok));
        o_status.fill_last = (r_k == LETTER_W'(LETTERS - 1));
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // square bookkeeping and fill walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= '0;
            r_k    <= '0;
        end else begin
            if (put_we) begin
                r_used[put_letter] <= 1'b1;
                r_fill             <= FILL_W'(r_fill + 1'b1);
            end
            if (i_cmd.fill_step) begin
                r_k <= o_status.fill_last ? '0 : LETTER_W'(r_k + 1'b1);
            end
        end
    end

    // held letter of an open pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else if (i_cmd.take) begin
            if (in_mode == MODE_MSG && in_ok) begin
                if (!r_held_valid) begin
                    r_held       <= i_in_letter;
                    r_held_valid <= 1'b1;
                end else if (i_in_letter != r_held) begin
                    r_held_valid <= 1'b0;
                end
            end else if (in_mode == MODE_END) begin
                r_held_valid <= 1'b0;
            end
        end
    end

    // pair operands captured at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_a         <= r_held;
            r_b         <= (in_mode == MODE_MSG && i_in_letter != r_held) ? i_in_letter
                                                                          : CODE_X;
            r_pair_last <= (in_mode == MODE_END);
        end
    end

    // letter to cell table
    assign place_raddr = PLACE_AW'(i_cmd.look_sel ? r_b : r_a);

    pfe_ram #(
        .WIDTH (CELL_AW),
        .DEPTH (LETTERS)
    ) u_place_ram (
        .i_clk   (i_clk),
        .i_we    (put_we),
        .i_waddr (PLACE_AW'(put_letter)),
        .i_wdata (r_fill[CELL_AW-1:0]),
        .i_raddr (place_raddr),
        .o_rdata (place_rdata)
    );

    // cell to letter table
    pfe_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (put_we),
        .i_waddr (r_fill[CELL_AW-1:0]),
        .i_wdata (put_letter),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // places of both letters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pa) begin
            r_pa <= place_rdata;
        end
        if (i_cmd.load_pb) begin
            r_pb <= place_rdata;
        end
    end

    // row, column and rectangle rules
    logic [RW-1:0]      r1, c1, r2, c2;
    logic [RW-1:0]      nr1, nc1, nr2, nc2;
    logic [CELL_AW-1:0] cell1, cell2;

    always_comb begin
        r1  = row_of(r_pa);
        c1  = col_of(r_pa, r1);
        r2  = row_of(r_pb);
        c2  = col_of(r_pb, r2);
        nr1 = r1;
        nc1 = c1;
        nr2 = r2;
        nc2 = c2;
        if (r1 == r2) begin
            nc1 = next_idx(c1);
            nc2 = next_idx(c2);
        end else if (c1 == c2) begin
            nr1 = next_idx(r1);
            nr2 = next_idx(r2);
        end else begin
            nc1 = c2;
            nc2 = c1;
        end
        cell1 = cell_at(nr1, nc1);
        cell2 = cell_at(nr2, nc2);
    end

    assign cell_raddr = i_cmd.cell_sel ? cell2 : cell1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first) begin
            r_first_hold <= cell_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_first  <= r_first_hold;
            r_second <= cell_rdata;
            r_last   <= r_pair_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_first  = r_first;
    assign o_cipher_second = r_second;
    assign o_last_pair     = r_last;

endmodule

`default_nettype wire

@@ src/playfair_encryptor.sv @@
// top level: playfair encryptor over the 25-letter alphabet without q
//
// input stream: s_axis_tuser carries the request kind (key letter, key done,
// message letter, message end), s_axis_tdata[4:0] the letter code A=0..Z=25.
// output stream: one request per enciphered pair, tdata holds both cipher
// letters, tlast marks the pair closed by message end.
// a key letter or a message letter that only opens a pair is taken without leaving idle.
// key done starts the fill, which walks all 26 letter codes, one a cycle.
// a letter that completes a pair runs two place lookups and two cell lookups,
// each through a single read port ram with registered read, then the result
// moves into the output register. one request is worked on at a time; tready
// is high only while idle. the output register holds a finished pair while
// the receiver stalls; a following pair waits in its last step until that
// register frees. reset clears the used-letter set, the fill count and the
// held letter; the square must be completed by key done before message
// letters are sent.
`default_nettype none

module playfair_encryptor
    import pfe_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [4:0] letter
    input  wire logic [MODE_W-1:0]     s_axis_tuser,  // [1:0] mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [4:0] cipher_first, [9:5] cipher_second
    output logic                       m_axis_tlast   // last_pair
);

    t_cmd                cmd;
    t_status             status;
    logic [LETTER_W-1:0] cipher_first;
    logic [LETTER_W-1:0] cipher_second;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfe_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_in_mode       (s_axis_tuser),
        .i_in_letter     (s_axis_tdata[LETTER_W-1:0]),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_out_valid     (m_axis_tvalid),
        .o_cipher_first  (cipher_first),
        .o_cipher_second (cipher_second),
        .o_last_pair     (m_axis_tlast)
    );

    assign s_axis_tready = cmd.ready;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2 * LETTER_W){1'b0}}, cipher_second, cipher_first};

    // a result is only loaded into a free output register
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("pair emitted into a busy output register");

    // a loaded result is offered on the next cycle
    a_emit_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("emitted pair not offered downstream");

    // no request is taken while the square fill runs
    a_fill_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fill_step |-> !s_axis_tready)
        else $error("input ready during square fill");

    // a pair lookup starts only from an accepted request
    a_pair_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_pa |-> $past(cmd.take, 2))
        else $error("pair lookup without an accepted request");

endmodule

`default_nettype wire
